// File: hdl/tridiagonal_system_solver_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the tridiagonal system solver
// ---------------------------------------------------------------------------
`ifndef TRIDIAGONAL_SYSTEM_SOLVER_UNIT_ASSERT_SVH
`define TRIDIAGONAL_SYSTEM_SOLVER_UNIT_ASSERT_SVH

// implication whose consequent is checked in the next cycle
`define TSS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tss assertion failed");

// condition that holds in every cycle
`define TSS_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("tss assertion failed");

`endif

// File: hdl/tss_pkg.sv
// ---------------------------------------------------------------------------
// tss_pkg
// Types and constants of the tridiagonal system solver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package tss_pkg;

    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int DEPTH = 64;

    typedef struct packed {
        logic signed [31:0] sub_diag;
        logic signed [31:0] main_diag;
        logic signed [31:0] super_diag;
        logic signed [31:0] rhs_value;
        logic               last_row;
    } row_t;

    typedef struct packed {
        logic signed [31:0] solution;
        logic [IDX_W-1:0]   row_index;
        logic               last_result;
        logic               zero_pivot;
    } res_t;

    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic               zero_den;
        logic signed [31:0] quot;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_F_WAIT,
        ST_F_DIV,
        ST_F_DIVW,
        ST_F_MUL1,
        ST_F_SUB1,
        ST_F_MUL2,
        ST_F_SUB2,
        ST_F_WR,
        ST_B_WAIT,
        ST_B_MUL,
        ST_B_SUB,
        ST_B_DIV,
        ST_B_DIVW,
        ST_E_WAIT,
        ST_E_OUT
    } state_t;

endpackage

// File: hdl/tss_div.sv
// ---------------------------------------------------------------------------
// tss_div
// Restoring Q16.16 divider, one quotient bit a cycle, saturated result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tss_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  tss_pkg::div_req_t  req,
    output tss_pkg::div_rsp_t  rsp
);
    import tss_pkg::*;

    localparam int DVD_W = 48;

    logic              busy_reg;
    logic [5:0]        cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [32:0]       rem_reg;
    logic [31:0]       dmag_reg;
    logic              neg_reg;
    logic              done_reg;
    logic              zden_reg;
    logic signed [31:0] quot_reg;

    logic [32:0]       num_ext;
    logic [32:0]       den_ext;
    logic [31:0]       num_mag;
    logic [31:0]       den_mag;
    logic [32:0]       rem_sh;
    logic [32:0]       rem_sub;
    logic              take;
    logic [DVD_W-1:0]  quo_fin;
    logic [31:0]       quo_neg;

    always_comb begin
        num_ext = {req.num[31], req.num};
        den_ext = {req.den[31], req.den};
        num_mag = req.num[31] ? 32'((~num_ext) + 33'd1) : req.num;
        den_mag = req.den[31] ? 32'((~den_ext) + 33'd1) : req.den;
        rem_sh  = {rem_reg[31:0], dvd_reg[DVD_W-1]};
        rem_sub = rem_sh - {1'b0, dmag_reg};
        take    = (rem_sh >= {1'b0, dmag_reg});
        quo_fin = {quo_reg[DVD_W-2:0], take};
        quo_neg = (~quo_fin[31:0]) + 32'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                if (req.den == 32'sd0) begin
                    done_reg <= 1'b1;
                    zden_reg <= 1'b1;
                    quot_reg <= req.num[31] ? 32'sh80000000 : 32'sh7FFFFFFF;
                end else begin
                    busy_reg <= 1'b1;
                    zden_reg <= 1'b0;
                    cnt_reg  <= 6'(DVD_W - 1);
                    dvd_reg  <= {num_mag, 16'd0};
                    quo_reg  <= '0;
                    rem_reg  <= '0;
                    dmag_reg <= den_mag;
                    neg_reg  <= req.num[31] ^ req.den[31];
                end
            end else if (busy_reg) begin
                rem_reg <= take ? rem_sub : rem_sh;
                dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
                quo_reg <= quo_fin;
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    if (neg_reg) begin
                        quot_reg <= (quo_fin > 48'h0000_8000_0000) ? 32'sh80000000
                                                                  : signed'(quo_neg);
                    end else begin
                        quot_reg <= (quo_fin > 48'h0000_7FFF_FFFF) ? 32'sh7FFFFFFF
                                                                  : signed'(quo_fin[31:0]);
                    end
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.zero_den = zden_reg;
    assign rsp.quot     = quot_reg;

endmodule

// File: hdl/tridiagonal_system_solver_unit.sv
// Elimination per row: read, divide by prior pivot, two multiply-subtracts, write.
// Back substitution per row: multiply, subtract, divide; then solutions are emitted.
// Throughput: one row request at a time; not ready while a row or a run is busy.
// Reset: aresetn, synchronous, active low, clears the sequencer, row count and flag.
// Stores are not cleared: a run reads only entries it has written.
// ---------------------------------------------------------------------------
// tridiagonal_system_solver_unit
// Thomas algorithm solver, Q16.16, shared divider and multiplier sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tridiagonal_system_solver_unit #(
    parameter int MAX_ROWS = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  tss_pkg::row_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output tss_pkg::res_t   m_data
);
    import tss_pkg::*;

    state_t state_reg, state_next;

    logic signed [31:0] pivot_mem [DEPTH];
    logic signed [31:0] rhs_mem   [DEPTH];
    logic signed [31:0] upper_mem [DEPTH];
    logic signed [31:0] sol_mem   [DEPTH];

    logic [IDX_W-1:0]   rd_addr_reg;
    logic signed [31:0] piv_q_reg, rhs_q_reg, up_q_reg, sol_q_reg;

    row_t               row_reg;
    logic [CNT_W-1:0]   rows_reg;
    logic               fault_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   last_idx_reg;
    logic [IDX_W-1:0]   i_reg;
    logic signed [31:0] beta_reg;
    logic signed [31:0] x_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] piv_new_reg, r_new_reg, num_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [CNT_W-1:0]   cnt_after;
    logic               run_end;
    logic               s_fire, m_fire;

    function automatic logic signed [31:0] sub_scaled(logic signed [31:0] a,
                                                      logic signed [63:0] p);
        logic signed [63:0] adj;
        logic signed [63:0] q;
        logic signed [31:0] qs;
        logic signed [33:0] diff;
        adj = p[63] ? (p + 64'sd65535) : p;
        q   = adj >>> 16;
        if (q > 64'sh7FFFFFFF) begin
            qs = 32'sh7FFFFFFF;
        end else if (q < -64'sh80000000) begin
            qs = 32'sh80000000;
        end else begin
            qs = q[31:0];
        end
        diff = 34'(a) - 34'(qs);
        if (diff > 34'sh7FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (diff < -34'sh80000000) begin
            return 32'sh80000000;
        end else begin
            return diff[31:0];
        end
    endfunction

    assign s_fire    = s_valid && s_ready;
    assign m_fire    = m_valid && m_ready;
    assign cnt_after = CNT_W'(idx_reg) + 7'd1;
    assign run_end   = row_reg.last_row || (cnt_after == CNT_W'(MAX_ROWS));

    tss_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_fire) begin
                state_next = (rows_reg == '0) ? ST_F_WR : ST_F_WAIT;
            end
            ST_F_WAIT: state_next = ST_F_DIV;
            ST_F_DIV:  state_next = ST_F_DIVW;
            ST_F_DIVW: if (div_rsp.done) begin
                state_next = ST_F_MUL1;
            end
            ST_F_MUL1: state_next = ST_F_SUB1;
            ST_F_SUB1: state_next = ST_F_MUL2;
            ST_F_MUL2: state_next = ST_F_SUB2;
            ST_F_SUB2: state_next = ST_F_WR;
            ST_F_WR:   state_next = run_end ? ST_B_WAIT : ST_IDLE;
            ST_B_WAIT: state_next = ST_B_MUL;
            ST_B_MUL:  state_next = ST_B_SUB;
            ST_B_SUB:  state_next = ST_B_DIV;
            ST_B_DIV:  state_next = ST_B_DIVW;
            ST_B_DIVW: if (div_rsp.done) begin
                state_next = (i_reg == '0) ? ST_E_WAIT : ST_B_WAIT;
            end
            ST_E_WAIT: state_next = ST_E_OUT;
            ST_E_OUT:  if (m_fire) begin
                state_next = (i_reg == '0) ? ST_IDLE : ST_E_WAIT;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        m_valid       = (state_reg == ST_E_OUT);
        div_req.start = (state_reg == ST_F_DIV) || (state_reg == ST_B_DIV);
        div_req.num   = (state_reg == ST_F_DIV) ? row_reg.sub_diag : num_reg;
        div_req.den   = piv_q_reg;
        m_data.solution    = sol_q_reg;
        m_data.row_index   = i_reg;
        m_data.last_result = (i_reg == '0);
        m_data.zero_pivot  = fault_reg;
    end

    always_ff @(posedge aclk) begin
        piv_q_reg <= pivot_mem[rd_addr_reg];
        rhs_q_reg <= rhs_mem[rd_addr_reg];
        up_q_reg  <= upper_mem[rd_addr_reg];
        sol_q_reg <= sol_mem[rd_addr_reg];
        if (state_reg == ST_F_WR) begin
            pivot_mem[idx_reg] <= piv_new_reg;
            rhs_mem[idx_reg]   <= r_new_reg;
            upper_mem[idx_reg] <= row_reg.super_diag;
        end
        if ((state_reg == ST_B_DIVW) && div_rsp.done) begin
            sol_mem[i_reg] <= div_rsp.quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rows_reg  <= '0;
            fault_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: if (s_fire) begin
                    row_reg     <= s_data;
                    idx_reg     <= rows_reg[IDX_W-1:0];
                    rd_addr_reg <= rows_reg[IDX_W-1:0] - 6'd1;
                    piv_new_reg <= s_data.main_diag;
                    r_new_reg   <= s_data.rhs_value;
                end
                ST_F_DIVW: if (div_rsp.done) begin
                    beta_reg  <= div_rsp.quot;
                    fault_reg <= fault_reg | div_rsp.zero_den;
                end
                ST_F_MUL1: prod_reg    <= beta_reg * up_q_reg;
                ST_F_SUB1: piv_new_reg <= sub_scaled(row_reg.main_diag, prod_reg);
                ST_F_MUL2: prod_reg    <= beta_reg * rhs_q_reg;
                ST_F_SUB2: r_new_reg   <= sub_scaled(row_reg.rhs_value, prod_reg);
                ST_F_WR: begin
                    rows_reg     <= cnt_after;
                    last_idx_reg <= idx_reg;
                    i_reg        <= idx_reg;
                    rd_addr_reg  <= idx_reg;
                    x_reg        <= '0;
                end
                ST_B_MUL:  prod_reg <= up_q_reg * x_reg;
                ST_B_SUB:  num_reg  <= (i_reg == last_idx_reg) ? rhs_q_reg
                                                               : sub_scaled(rhs_q_reg, prod_reg);
                ST_B_DIVW: if (div_rsp.done) begin
                    x_reg     <= div_rsp.quot;
                    fault_reg <= fault_reg | div_rsp.zero_den;
                    if (i_reg == '0) begin
                        i_reg       <= last_idx_reg;
                        rd_addr_reg <= last_idx_reg;
                    end else begin
                        i_reg       <= i_reg - 6'd1;
                        rd_addr_reg <= i_reg - 6'd1;
                    end
                end
                ST_E_OUT: if (m_fire) begin
                    if (i_reg == '0) begin
                        rows_reg  <= '0;
                        fault_reg <= 1'b0;
                    end else begin
                        i_reg       <= i_reg - 6'd1;
                        rd_addr_reg <= i_reg - 6'd1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// File: hdl/tss_checker.sv
// ---------------------------------------------------------------------------
// tss_checker
// Port-level assertions for the tridiagonal system solver, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tridiagonal_system_solver_unit_assert.svh"
module tss_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input tss_pkg::res_t m_data
);
    import tss_pkg::*;

    `TSS_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid)
    `TSS_ASSERT_ALWAYS(a_no_overlap, aclk, aresetn, !(s_ready && m_valid))
    `TSS_ASSERT_NEXT(a_end_ready, aclk, aresetn, m_valid && m_ready && m_data.last_result, s_ready)
    `TSS_ASSERT_NEXT(a_mid_busy, aclk, aresetn, m_valid && m_ready && !m_data.last_result, !s_ready)

endmodule

bind tridiagonal_system_solver_unit tss_checker u_tss_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the tridiagonal system solver: rows are driven as
// whole systems, a local fixed-point Thomas solver predicts each solution.
// ---------------------------------------------------------------------------
module tb;
    import tss_pkg::*;

    localparam int MAXR = 64;
    localparam int LIMIT = 3000000;

    class solution_board;
        logic signed [31:0] piv_mem [MAXR];
        logic signed [31:0] rhs_mem [MAXR];
        logic signed [31:0] up_mem [MAXR];
        int rows;
        bit fault;
        res_t pending[$];
        int errors;
        int seen;

        function new();
            rows = 0;
            fault = 0;
            errors = 0;
            seen = 0;
        endfunction

        function logic signed [31:0] clip(longint v);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        function logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
            longint p;
            p = longint'(a) * longint'(b);
            return clip(p / 65536);
        endfunction

        function logic signed [31:0] fx_div(logic signed [31:0] num, logic signed [31:0] den);
            if (den == 0) begin
                fault = 1;
                return (num < 0) ? 32'sh80000000 : 32'sh7fffffff;
            end
            return clip((longint'(num) * 65536) / longint'(den));
        endfunction

        function void note_row(row_t r);
            int idx;
            int n;
            logic signed [31:0] piv, rv, beta, num, x;
            logic signed [31:0] sol [MAXR];
            res_t e;
            idx = rows % MAXR;
            x = 0;
            if (idx == 0) begin
                piv = r.main_diag;
                rv = r.rhs_value;
            end else begin
                beta = fx_div(r.sub_diag, piv_mem[idx-1]);
                piv = clip(longint'(r.main_diag) - longint'(fx_mul(beta, up_mem[idx-1])));
                rv = clip(longint'(r.rhs_value) - longint'(fx_mul(beta, rhs_mem[idx-1])));
            end
            piv_mem[idx] = piv;
            rhs_mem[idx] = rv;
            up_mem[idx] = r.super_diag;
            rows = idx + 1;
            if (!r.last_row && rows < MAXR) return;
            n = rows;
            for (int i = n - 1; i >= 0; i--) begin
                if (i == n - 1) num = rhs_mem[i];
                else num = clip(longint'(rhs_mem[i]) - longint'(fx_mul(up_mem[i], x)));
                x = fx_div(num, piv_mem[i]);
                sol[i] = x;
            end
            for (int j = n - 1; j >= 0; j--) begin
                e.solution = sol[j];
                e.row_index = j[5:0];
                e.last_result = (j == 0);
                e.zero_pivot = fault;
                pending.push_back(e);
            end
            rows = 0;
            fault = 0;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %s: got %h want %h", what, got, want);
        endtask

        task check_result(res_t g);
            res_t w;
            seen++;
            if (pending.size() == 0) begin
                report("unexpected solution", g.solution, 0);
                return;
            end
            w = pending.pop_front();
            if (g.solution !== w.solution) report("solution", g.solution, w.solution);
            if (g.row_index !== w.row_index) report("row_index", g.row_index, w.row_index);
            if (g.last_result !== w.last_result)
                report("last_result", g.last_result, w.last_result);
            if (g.zero_pivot !== w.zero_pivot)
                report("zero_pivot", g.zero_pivot, w.zero_pivot);
        endtask
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    row_t s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    res_t m_data;

    solution_board board = new();
    int src_idle = 0;
    int snk_idle = 0;
    int cycles = 0;
    int systems = 0;

    tridiagonal_system_solver_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
        if (!aresetn) m_ready <= 0;
        else m_ready <= ($urandom_range(99) >= snk_idle);
    end

    task send_row(row_t r);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_row(r);
        if (r.last_row || board.rows == 0) systems++;
    endtask

    function logic signed [31:0] rnd_val(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
            default: return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
        endcase
    endfunction

    task send_system(int n, int mode);
        row_t r;
        for (int i = 0; i < n; i++) begin
            r.sub_diag = rnd_val(mode);
            r.super_diag = rnd_val(mode);
            r.rhs_value = rnd_val(mode);
            r.main_diag = (mode == 2) ? 32'sh0040_0000 + rnd_val(1) : rnd_val(mode);
            if (mode != 0 && $urandom_range(19) == 0) r.main_diag = 0;
            r.last_row = (i == n - 1);
            send_row(r);
        end
    endtask

    task wait_drain();
        s_valid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    task directed();
        row_t r;
        r = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b1};
        send_row(r);
        r = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b1};
        send_row(r);
        r = '{32'sh0, 32'sh0, 32'sh0, 32'shffff_0000, 1'b1};
        send_row(r);
        r = '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b1};
        send_row(r);
        r = '{32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000, 32'sh0003_0000, 1'b0};
        send_row(r);
        r = '{32'sh0001_0000, 32'sh0, 32'sh0001_0000, 32'sh0001_0000, 1'b0};
        send_row(r);
        r = '{32'sh0001_0000, 32'sh0002_0000, 32'sh7fffffff, 32'shfffe_0000, 1'b1};
        send_row(r);
        r = '{32'shffffffff, 32'sh0000_0001, 32'shffffffff, 32'sh0000_0001, 1'b0};
        send_row(r);
        r = '{32'sh7fffffff, 32'sh0000_0001, 32'sh0, 32'sh7fffffff, 1'b1};
        send_row(r);
        // full store: 64 rows with no marker end the system
        for (int i = 0; i < MAXR; i++) begin
            r.sub_diag = rnd_val(1);
            r.main_diag = 32'sh0040_0000 + rnd_val(1);
            r.super_diag = rnd_val(1);
            r.rhs_value = rnd_val(0);
            r.last_row = 0;
            send_row(r);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        src_idle = 6;
        snk_idle = 68;
        directed();
        wait_drain();
        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 6 : (ph == 1) ? 68 : 0;
            snk_idle = (ph == 0) ? 68 : (ph == 1) ? 6 : 0;
            for (int k = 0; k < 10; k++) begin
                send_system($urandom_range(1, 12), $urandom_range(2));
                if ($urandom_range(3) == 0) wait_drain();
            end
            wait_drain();
        end
        repeat (400) @(posedge aclk);
        $display("covered %0d systems, %0d solutions checked incl. zero pivots and full store",
                 systems, board.seen);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// File: tridiagonal_system_solver_unit.f
+incdir+hdl
hdl/tss_pkg.sv
hdl/tss_div.sv
hdl/tridiagonal_system_solver_unit.sv
hdl/tss_checker.sv
tb/tb.sv
